FILE: sv/iouga_pkg.sv
// Shared types and constants for the greedy IoU association block.
// Used by the interfaces, the controller, the datapath and the top level.
package iouga_pkg;

	localparam int MAX_DETS      = 16;
	localparam int MAX_TRKS      = 16;
	localparam int IDX_W         = 4;
	localparam int CNT_W         = 5;
	localparam int IOU_FRAC_BITS = 16;
	localparam int IOU_W         = IOU_FRAC_BITS + 1;
	localparam int SIDE_W        = 12;
	localparam int AREA_W        = 2 * SIDE_W;
	localparam int UNI_W         = AREA_W + 1;
	localparam int TBL_AW        = 2 * IDX_W;
	localparam int TBL_DEPTH     = MAX_DETS * MAX_TRKS;
	localparam int APB_AW        = 3;

	localparam logic [IOU_W-1:0] THR_RESET = IOU_W'(19661);

	// register word index taken from paddr[2]
	localparam logic REG_THR = 1'b0;

	localparam logic [1:0] REQ_DET = 2'd0;
	localparam logic [1:0] REQ_TRK = 2'd1;
	localparam logic [1:0] REQ_RUN = 2'd2;

	localparam logic [1:0] KIND_MATCH = 2'd0;
	localparam logic [1:0] KIND_DET   = 2'd1;
	localparam logic [1:0] KIND_TRK   = 2'd2;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [SIDE_W-1:0]  w;
		logic [SIDE_W-1:0]  h;
	} box_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [IDX_W-1:0] det_index;
		logic [IDX_W-1:0] trk_index;
		logic [IOU_W-1:0] iou_value;
		logic             dropped;
		logic             last;
	} res_t;

	typedef struct packed {
		logic             load_det;
		logic             load_trk;
		logic             pair_rd;
		logic             calc1;
		logic             calc2;
		logic             calc3;
		logic             div_start;
		logic             tbl_wr;
		logic             scan_init;
		logic             scan_rd;
		logic             take;
		logic             gen_match;
		logic             gen_det;
		logic             gen_trk;
		logic             flush;
		logic             clear;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] det_cnt;
		logic [CNT_W-1:0] trk_cnt;
		logic             div_done;
		logic             found;
		logic             best_ok;
		logic             det_ok_i;
		logic             trk_ok_j;
		logic             out_free;
		logic             pend_v;
	} sts_t;

endpackage

FILE: sv/iouga_ifs.sv
// Valid/ready channel interfaces for box requests and association results.
// Depends on iouga_pkg.
interface iouga_req_if;
	import iouga_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [15:0] box_x;
	logic signed [15:0] box_y;
	logic [SIDE_W-1:0]  box_w;
	logic [SIDE_W-1:0]  box_h;
	modport source(output valid, req_type, box_x, box_y, box_w, box_h, input ready);
	modport sink(input valid, req_type, box_x, box_y, box_w, box_h, output ready);
endinterface

interface iouga_res_if;
	import iouga_pkg::*;
	logic             valid;
	logic             ready;
	logic [1:0]       kind;
	logic [IDX_W-1:0] det_index;
	logic [IDX_W-1:0] trk_index;
	logic [IOU_W-1:0] iou_value;
	logic             dropped;
	logic             last;
	modport source(output valid, kind, det_index, trk_index, iou_value, dropped, last,
		input ready);
	modport sink(input valid, kind, det_index, trk_index, iou_value, dropped, last,
		output ready);
endinterface

FILE: sv/iouga_div.sv
// Restoring divider, one quotient bit per cycle: floor(num * 2^IOU_FRAC_BITS / den).
// Assumes num <= den; den of zero gives zero. Depends on iouga_pkg.
module iouga_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [iouga_pkg::AREA_W-1:0] num,
	input  logic [iouga_pkg::UNI_W-1:0]  den,
	output logic                        done,
	output logic [iouga_pkg::IOU_W-1:0]  quo
);
	import iouga_pkg::*;

	localparam int STEP_W = $clog2(IOU_FRAC_BITS + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [UNI_W-1:0]  rem_q;
	logic [UNI_W-1:0]  den_q;
	logic [IOU_W-1:0]  quo_q;
	logic [UNI_W:0]    rem2;
	logic              bit_n;

	assign rem2  = {rem_q, 1'b0};
	assign bit_n = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= den != '0;
				done_q <= den == '0;
				step_q <= STEP_W'(IOU_FRAC_BITS);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			if (den == '0) begin
				quo_q <= '0;
				rem_q <= '0;
			end else if ({1'b0, num} >= den) begin
				// integer bit of the quotient
				quo_q <= IOU_W'(1);
				rem_q <= {1'b0, num} - den;
			end else begin
				quo_q <= '0;
				rem_q <= {1'b0, num};
			end
		end else if (busy_q) begin
			quo_q <= {quo_q[IOU_W-2:0], bit_n};
			rem_q <= bit_n ? UNI_W'(rem2 - {1'b0, den_q}) : UNI_W'(rem2);
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

FILE: sv/iouga_dp.sv
// Datapath: box stores, pair IoU arithmetic, IoU table, greedy search, result buffer.
// Depends on iouga_pkg and iouga_div.
module iouga_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  iouga_pkg::cmd_t            cmd,
	output iouga_pkg::sts_t            sts,
	input  iouga_pkg::box_t            in_box,
	input  logic [iouga_pkg::IOU_W-1:0] thr,
	output iouga_pkg::res_t            out_res,
	output logic                       out_valid,
	input  logic                       out_ready
);
	import iouga_pkg::*;

	box_t              det_mem [MAX_DETS];
	box_t              trk_mem [MAX_TRKS];
	logic [IOU_W-1:0]  tbl_mem [TBL_DEPTH];
	logic [CNT_W-1:0]  det_cnt_q, trk_cnt_q;
	logic              ovf_q;
	box_t              dbox_q, tbox_q;
	logic [SIDE_W-1:0] iw_q, ih_q;
	logic [AREA_W-1:0] area_d_q, area_t_q, inter_q;
	logic [UNI_W-1:0]  uni_q;
	logic              div_done;
	logic [IOU_W-1:0]  div_quo;
	logic [IOU_W-1:0]  tbl_s1;
	logic              v_s1;
	logic [IDX_W-1:0]  bi_s1, bj_s1;
	logic [IOU_W-1:0]  best_q;
	logic [IDX_W-1:0]  bi_q, bj_q;
	logic              found_q;
	logic [MAX_DETS-1:0] dtaken_q, dok_q;
	logic [MAX_TRKS-1:0] ttaken_q, tok_q;
	res_t              pend_q, out_q, gen;
	logic              pend_v_q, out_v_q;
	logic              gen_any, push, better;
	logic [SIDE_W-1:0] iw, ih;

	iouga_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (inter_q),
		.den   (uni_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// overlap extent along one axis, clamped at zero; never exceeds either side
	function automatic logic [SIDE_W-1:0] overlap(input logic signed [15:0] a,
		input logic [SIDE_W-1:0] aw, input logic signed [15:0] b,
		input logic [SIDE_W-1:0] bw);
		logic signed [16:0] lo, a2, b2, hi;
		logic signed [17:0] d;
		lo = (a > b) ? 17'(a) : 17'(b);
		a2 = 17'(a) + $signed({5'b0, aw});
		b2 = 17'(b) + $signed({5'b0, bw});
		hi = (a2 < b2) ? a2 : b2;
		d  = 18'(hi) - 18'(lo);
		overlap = (d > 18'sd0) ? d[SIDE_W-1:0] : '0;
	endfunction

	assign iw = overlap(dbox_q.x, dbox_q.w, tbox_q.x, tbox_q.w);
	assign ih = overlap(dbox_q.y, dbox_q.h, tbox_q.y, tbox_q.h);

	always_ff @(posedge clk) begin
		if (cmd.load_det && det_cnt_q < CNT_W'(MAX_DETS))
			det_mem[det_cnt_q[IDX_W-1:0]] <= in_box;
		if (cmd.load_trk && trk_cnt_q < CNT_W'(MAX_TRKS))
			trk_mem[trk_cnt_q[IDX_W-1:0]] <= in_box;
		if (cmd.pair_rd) begin
			dbox_q <= det_mem[cmd.i];
			tbox_q <= trk_mem[cmd.j];
		end
		if (cmd.calc1) begin
			iw_q     <= iw;
			ih_q     <= ih;
			area_d_q <= dbox_q.w * dbox_q.h;
		end
		if (cmd.calc2) begin
			area_t_q <= tbox_q.w * tbox_q.h;
			inter_q  <= iw_q * ih_q;
		end
		if (cmd.calc3)
			uni_q <= {1'b0, area_d_q} + {1'b0, area_t_q} - {1'b0, inter_q};
		if (cmd.tbl_wr)
			tbl_mem[{cmd.i, cmd.j}] <= div_quo;
		if (cmd.scan_rd) begin
			tbl_s1 <= tbl_mem[{cmd.i, cmd.j}];
			bi_s1  <= cmd.i;
			bj_s1  <= cmd.j;
		end
		if (better) begin
			best_q <= tbl_s1;
			bi_q   <= bi_s1;
			bj_q   <= bj_s1;
		end
		if (gen_any)
			pend_q <= gen;
		if (cmd.flush) begin
			out_q      <= pend_q;
			out_q.last <= 1'b1;
		end else if (push) begin
			out_q <= pend_q;
		end
	end

	// strict compare in row-major scan order: ties keep the lowest detection, then track
	assign better  = v_s1 && (!found_q || tbl_s1 > best_q);
	assign gen_any = cmd.gen_match | cmd.gen_det | cmd.gen_trk;
	assign push    = (gen_any & pend_v_q) | cmd.flush;

	always_comb begin
		gen = '0;
		gen.dropped = ovf_q;
		if (cmd.gen_match) begin
			gen.kind      = KIND_MATCH;
			gen.det_index = bi_q;
			gen.trk_index = bj_q;
			gen.iou_value = best_q;
		end else if (cmd.gen_det) begin
			gen.kind      = KIND_DET;
			gen.det_index = cmd.i;
		end else begin
			gen.kind      = KIND_TRK;
			gen.trk_index = cmd.j;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_cnt_q <= '0;
			trk_cnt_q <= '0;
			ovf_q     <= 1'b0;
			v_s1      <= 1'b0;
			found_q   <= 1'b0;
			dtaken_q  <= '0;
			ttaken_q  <= '0;
			dok_q     <= '0;
			tok_q     <= '0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cmd.load_det) begin
				if (det_cnt_q < CNT_W'(MAX_DETS))
					det_cnt_q <= det_cnt_q + CNT_W'(1);
				else
					ovf_q <= 1'b1;
			end
			if (cmd.load_trk) begin
				if (trk_cnt_q < CNT_W'(MAX_TRKS))
					trk_cnt_q <= trk_cnt_q + CNT_W'(1);
				else
					ovf_q <= 1'b1;
			end
			v_s1 <= cmd.scan_rd && !dtaken_q[cmd.i] && !ttaken_q[cmd.j];
			if (cmd.scan_init || cmd.take)
				found_q <= 1'b0;
			else if (better)
				found_q <= 1'b1;
			if (cmd.take) begin
				dtaken_q[bi_q] <= 1'b1;
				ttaken_q[bj_q] <= 1'b1;
			end
			if (cmd.gen_match) begin
				dok_q[bi_q] <= 1'b1;
				tok_q[bj_q] <= 1'b1;
			end
			if (gen_any)
				pend_v_q <= 1'b1;
			else if (cmd.flush)
				pend_v_q <= 1'b0;
			if (push)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
			if (cmd.clear) begin
				det_cnt_q <= '0;
				trk_cnt_q <= '0;
				ovf_q     <= 1'b0;
				found_q   <= 1'b0;
				dtaken_q  <= '0;
				ttaken_q  <= '0;
				dok_q     <= '0;
				tok_q     <= '0;
			end
		end
	end

	assign sts.det_cnt  = det_cnt_q;
	assign sts.trk_cnt  = trk_cnt_q;
	assign sts.div_done = div_done;
	assign sts.found    = found_q;
	assign sts.best_ok  = best_q >= thr;
	assign sts.det_ok_i = dok_q[cmd.i];
	assign sts.trk_ok_j = tok_q[cmd.j];
	assign sts.out_free = !out_v_q || out_ready;
	assign sts.pend_v   = pend_v_q;

	assign out_res   = out_q;
	assign out_valid = out_v_q;
endmodule

FILE: sv/iouga_ctrl.sv
// Controller: sequences loads, the pair IoU pass, greedy rounds and result emission.
// Depends on iouga_pkg; drives the datapath through cmd_t and reads sts_t.
module iouga_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      in_req,
	output logic            in_ready,
	output iouga_pkg::cmd_t cmd,
	input  iouga_pkg::sts_t sts
);
	import iouga_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PRD, S_C1, S_C2, S_C3, S_DIV, S_DWAIT, S_WR,
		S_SCAN, S_DRAIN, S_TAKE, S_UNMD, S_UNMT, S_FLUSH, S_CLEAR
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] i_q, j_q;
	logic             last_i, last_j;

	assign last_i = i_q == sts.det_cnt - CNT_W'(1);
	assign last_j = j_q == sts.trk_cnt - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_req == REQ_RUN) begin
						i_q <= '0;
						j_q <= '0;
						if (sts.det_cnt == '0 || sts.trk_cnt == '0)
							state_q <= S_UNMD;
						else
							state_q <= S_PRD;
					end
				end
				S_PRD:   state_q <= S_C1;
				S_C1:    state_q <= S_C2;
				S_C2:    state_q <= S_C3;
				S_C3:    state_q <= S_DIV;
				S_DIV:   state_q <= S_DWAIT;
				S_DWAIT: begin
					if (sts.div_done)
						state_q <= S_WR;
				end
				S_WR, S_SCAN: begin
					if (last_j) begin
						j_q <= '0;
						if (last_i) begin
							i_q     <= '0;
							state_q <= (state_q == S_WR) ? S_SCAN : S_DRAIN;
						end else begin
							i_q <= i_q + CNT_W'(1);
							if (state_q == S_WR)
								state_q <= S_PRD;
						end
					end else begin
						j_q <= j_q + CNT_W'(1);
						if (state_q == S_WR)
							state_q <= S_PRD;
					end
				end
				S_DRAIN: state_q <= S_TAKE;
				S_TAKE: begin
					if (!sts.found)
						state_q <= S_UNMD;
					else if (!sts.best_ok || sts.out_free)
						state_q <= S_SCAN;
				end
				S_UNMD: begin
					if (i_q >= sts.det_cnt) begin
						j_q     <= '0;
						state_q <= S_UNMT;
					end else if (sts.det_ok_i || sts.out_free) begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				S_UNMT: begin
					if (j_q >= sts.trk_cnt)
						state_q <= S_FLUSH;
					else if (sts.trk_ok_j || sts.out_free)
						j_q <= j_q + CNT_W'(1);
				end
				S_FLUSH: begin
					if (!sts.pend_v || sts.out_free)
						state_q <= S_CLEAR;
				end
				S_CLEAR: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd   = '0;
		cmd.i = i_q[IDX_W-1:0];
		cmd.j = j_q[IDX_W-1:0];
		case (state_q)
			S_IDLE: begin
				cmd.load_det = in_valid && in_req == REQ_DET;
				cmd.load_trk = in_valid && in_req == REQ_TRK;
			end
			S_PRD:  cmd.pair_rd = 1'b1;
			S_C1:   cmd.calc1 = 1'b1;
			S_C2:   cmd.calc2 = 1'b1;
			S_C3:   cmd.calc3 = 1'b1;
			S_DIV:  cmd.div_start = 1'b1;
			S_WR: begin
				cmd.tbl_wr    = 1'b1;
				cmd.scan_init = last_i && last_j;
			end
			S_SCAN: cmd.scan_rd = 1'b1;
			S_TAKE: begin
				cmd.take      = sts.found && (!sts.best_ok || sts.out_free);
				cmd.gen_match = sts.found && sts.best_ok && sts.out_free;
			end
			S_UNMD: cmd.gen_det = i_q < sts.det_cnt && !sts.det_ok_i && sts.out_free;
			S_UNMT: cmd.gen_trk = j_q < sts.trk_cnt && !sts.trk_ok_j && sts.out_free;
			S_FLUSH: cmd.flush = sts.pend_v && sts.out_free;
			S_CLEAR: cmd.clear = 1'b1;
			default: cmd.clear = 1'b0;
		endcase
	end

	assign in_ready = state_q == S_IDLE;
endmodule

FILE: sv/iou_greedy_association.sv
// Top level of greedy IoU association: APB threshold register, controller, datapath.
// Depends on iouga_pkg, iouga_ifs, iouga_ctrl and iouga_dp.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        req_type, box_x, box_y, box_w, box_h
//   res      out  valid/ready        kind, det_index, trk_index, iou_value, dropped, last
//   apb      in   psel/penable       paddr, pwdata, pwrite -> prdata, pready
//
// Load items are accepted only while idle. If both counts are nonzero, a run computes the
// IoU of every box pair, waiting on the divider unless the union is zero, then runs
// min(dets,trks)+1 greedy rounds over the IoU table; it then reports each unmatched box.
// Results pass through a one-entry pending buffer and an output register; a stalled res
// side holds the controller in place.
// Reset clears counts, flags and handshakes; box stores and the IoU table are not cleared.
module iou_greedy_association (
	input  logic                         clk,
	input  logic                         arst_n,
	iouga_req_if.sink                    req,
	iouga_res_if.source                  res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [iouga_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import iouga_pkg::*;

	logic [IOU_W-1:0] thr_q;
	cmd_t             cmd;
	sts_t             sts;
	box_t             in_box;
	res_t             out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thr_q <= THR_RESET;
		else if (psel && penable && pwrite && paddr[2] == REG_THR)
			thr_q <= pwdata[IOU_W-1:0];
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_THR) ? {{(32-IOU_W){1'b0}}, thr_q} : '0;

	assign in_box.x = req.box_x;
	assign in_box.y = req.box_y;
	assign in_box.w = req.box_w;
	assign in_box.h = req.box_h;

	iouga_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_req  (req.req_type),
		.in_ready(req.ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	iouga_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_box   (in_box),
		.thr      (thr_q),
		.out_res  (out_res),
		.out_valid(res.valid),
		.out_ready(res.ready)
	);

	assign res.kind      = out_res.kind;
	assign res.det_index = out_res.det_index;
	assign res.trk_index = out_res.trk_index;
	assign res.iou_value = out_res.iou_value;
	assign res.dropped   = out_res.dropped;
	assign res.last      = out_res.last;

	a_iou_only_match: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind != KIND_MATCH |-> res.iou_value == '0)
		else $error("nonzero IoU on an unmatched result");

	a_iou_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.iou_value <= IOU_W'(1 << IOU_FRAC_BITS))
		else $error("IoU above one");

	a_match_thr: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind == KIND_MATCH |-> res.iou_value >= thr_q)
		else $error("match below threshold");

	a_busy_no_req: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !req.ready || !res.last || !$stable(res.valid) || res.ready
			|| sts.pend_v == 1'b0)
		else $error("pending result left behind after the final transfer");
endmodule
